// File: rtl/core/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg - shared types and constants of the heap sort rank assigner
// Entry layout, field widths and sequencer states.
// ----------------------------------------------------------------------------
package hsr_pkg;

   localparam int CAPACITY  = 64;
   localparam int SCORE_W   = 32;
   localparam int POS_W     = 6;
   localparam int RANK_W    = 7;
   localparam int FILL_W    = 7;
   localparam int ENTRY_W   = SCORE_W + POS_W;
   localparam int DEPTH     = 2 ** POS_W;

   localparam logic [FILL_W-1:0] CAP_COUNT = FILL_W'(CAPACITY);

   typedef logic [ENTRY_W-1:0] entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_HOLD,
      ST_KIDS,
      ST_CMP,
      ST_POP_RD,
      ST_POP
   } state_type;

endpackage

// File: rtl/core/hsr_if.sv
// ----------------------------------------------------------------------------
// hsr_req_if / hsr_rsp_if - valid/ready channels of the rank assigner
// Score beats in, ranked position beats out.
// ----------------------------------------------------------------------------
interface hsr_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [hsr_pkg::SCORE_W-1:0] score;
   logic                             set_end;

   modport source (output valid, output score, output set_end, input ready);
   modport sink   (input valid, input score, input set_end, output ready);
endinterface

interface hsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsr_pkg::POS_W-1:0]   position;
   logic [hsr_pkg::RANK_W-1:0]  rank;
   logic                        run_end;
   logic                        overflow;

   modport source (output valid, output position, output rank, output run_end,
                   output overflow, input ready);
   modport sink   (input valid, input position, input rank, input run_end,
                   input overflow, output ready);
endinterface

// File: rtl/core/heap_sort_rank_assigner.sv
// A score beat without set_end is stored in the heap memory. After the
// set_end beat, the heap build runs one sift per internal node, and then each
// pop re-sifts the heap; a sift walks at most depth levels, depth = log2 of
// the set size (6 at 64), under the single two-read-port heap memory and one compare sequencer.
// No new score is taken while a set is being built and popped.
// Reset clears the sequencer, fill count and overflow flag; the heap store is not cleared.
// ----------------------------------------------------------------------------
// heap_sort_rank_assigner - binary max-heap ranking of a set of scores
// Stores (score, position) entries, builds a max-heap on the last beat and
// pops it, emitting position and rank of each score, highest first.
// ----------------------------------------------------------------------------
module heap_sort_rank_assigner (
   input  logic      clock,
   input  logic      reset,
   hsr_req_if.sink   req_bus,
   hsr_rsp_if.source rsp_bus
);

   hsr_pkg::state_type state_ff, state_in;

   logic [hsr_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic                       ovf_ff, ovf_in;
   logic                       pop_phase_ff, pop_phase_in;
   logic [hsr_pkg::POS_W-1:0]  bld_ff, bld_in;
   logic [hsr_pkg::POS_W-1:0]  idx_ff, idx_in;
   logic [hsr_pkg::FILL_W-1:0] sift_n_ff, sift_n_in;
   logic [hsr_pkg::FILL_W-1:0] k_ff, k_in;
   hsr_pkg::entry_type         hold_ff, hold_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hsr_pkg::POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [hsr_pkg::RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic                        rsp_end_ff, rsp_end_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   // heap memory: one write port, two registered read ports
   hsr_pkg::entry_type        heap_mem [hsr_pkg::DEPTH];
   hsr_pkg::entry_type        rd0_ff, rd1_ff;
   logic [hsr_pkg::POS_W-1:0] rd_addr0, rd_addr1;
   logic                      wr_en;
   logic [hsr_pkg::POS_W-1:0] wr_addr;
   hsr_pkg::entry_type        wr_data;

   logic                       accept;
   logic                       has_room;
   logic [hsr_pkg::FILL_W-1:0] n_new;
   logic [hsr_pkg::FILL_W-1:0] left;
   logic [hsr_pkg::FILL_W:0]   right;
   logic                       has_left;
   logic                       has_right;
   logic                       pick_right;
   hsr_pkg::entry_type         big_val;
   logic [hsr_pkg::POS_W-1:0]  big_idx;
   logic                       move;
   logic                       sift_done;
   logic [hsr_pkg::FILL_W-1:0] last;
   logic                       out_free;

   assign req_bus.ready     = (state_ff == hsr_pkg::ST_IDLE);
   assign accept            = req_bus.valid && req_bus.ready;
   assign has_room          = (fill_ff < hsr_pkg::CAP_COUNT);
   assign n_new             = has_room ? fill_ff + 1'b1 : fill_ff;

   assign left       = {idx_ff, 1'b1};
   assign right      = {1'b0, left} + 1'b1;
   assign has_left   = (left < sift_n_ff);
   assign has_right  = (right < {1'b0, sift_n_ff});
   assign pick_right = has_right && !(rd0_ff > rd1_ff);
   assign big_val    = pick_right ? rd1_ff : rd0_ff;
   assign big_idx    = pick_right ? right[hsr_pkg::POS_W-1:0] : left[hsr_pkg::POS_W-1:0];
   assign move       = (big_val > hold_ff);
   assign sift_done  = ((state_ff == hsr_pkg::ST_KIDS) && !has_left)
                    || ((state_ff == hsr_pkg::ST_CMP) && !move);
   assign last       = fill_ff - 1'b1 - k_ff;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsr_pkg::ST_IDLE: begin
            if (accept && req_bus.set_end) begin
               state_in = (n_new > 7'd1) ? hsr_pkg::ST_FETCH : hsr_pkg::ST_POP_RD;
            end
         end
         hsr_pkg::ST_FETCH: state_in = hsr_pkg::ST_HOLD;
         hsr_pkg::ST_HOLD:  state_in = hsr_pkg::ST_KIDS;
         hsr_pkg::ST_KIDS,
         hsr_pkg::ST_CMP: begin
            if ((state_ff == hsr_pkg::ST_KIDS) && has_left) begin
               state_in = hsr_pkg::ST_CMP;
            end else if ((state_ff == hsr_pkg::ST_CMP) && move) begin
               state_in = hsr_pkg::ST_KIDS;
            end else if (!pop_phase_ff) begin
               state_in = (bld_ff == '0) ? hsr_pkg::ST_POP_RD : hsr_pkg::ST_FETCH;
            end else begin
               state_in = (k_ff == fill_ff) ? hsr_pkg::ST_IDLE : hsr_pkg::ST_POP_RD;
            end
         end
         hsr_pkg::ST_POP_RD: state_in = hsr_pkg::ST_POP;
         hsr_pkg::ST_POP: begin
            if (out_free) begin
               state_in = hsr_pkg::ST_KIDS;
            end
         end
         default: state_in = hsr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      pop_phase_in = pop_phase_ff;
      bld_in       = bld_ff;
      idx_in       = idx_ff;
      sift_n_in    = sift_n_ff;
      k_in         = k_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_addr0     = '0;
      rd_addr1     = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = hold_ff;

      case (state_ff)
         hsr_pkg::ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  // flip the sign so an unsigned compare orders the scores
                  wr_en   = 1'b1;
                  wr_addr = fill_ff[hsr_pkg::POS_W-1:0];
                  wr_data = {req_bus.score ^ {1'b1, {(hsr_pkg::SCORE_W-1){1'b0}}},
                             fill_ff[hsr_pkg::POS_W-1:0]};
                  fill_in = fill_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.set_end) begin
                  sift_n_in    = n_new;
                  bld_in       = hsr_pkg::POS_W'((n_new >> 1) - 1'b1);
                  idx_in       = hsr_pkg::POS_W'((n_new >> 1) - 1'b1);
                  pop_phase_in = (n_new < 7'd2);
                  k_in         = '0;
               end
            end
         end
         hsr_pkg::ST_FETCH: begin
            rd_addr0 = idx_ff;
         end
         hsr_pkg::ST_HOLD: begin
            hold_in = rd0_ff;
         end
         hsr_pkg::ST_KIDS: begin
            rd_addr0 = left[hsr_pkg::POS_W-1:0];
            rd_addr1 = right[hsr_pkg::POS_W-1:0];
            if (!has_left) begin
               wr_en = 1'b1;
            end
         end
         hsr_pkg::ST_CMP: begin
            wr_en = 1'b1;
            if (move) begin
               // larger child moves up, hole moves down
               wr_data = big_val;
               idx_in  = big_idx;
            end
         end
         hsr_pkg::ST_POP_RD,
         hsr_pkg::ST_POP: begin
            rd_addr0 = '0;
            rd_addr1 = last[hsr_pkg::POS_W-1:0];
            if ((state_ff == hsr_pkg::ST_POP) && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = rd0_ff[hsr_pkg::POS_W-1:0];
               rsp_rank_in  = k_ff + 1'b1;
               rsp_end_in   = ((k_ff + 1'b1) == fill_ff);
               rsp_ovf_in   = ovf_ff;
               hold_in      = rd1_ff;
               idx_in       = '0;
               sift_n_in    = last;
               k_in         = k_ff + 1'b1;
            end
         end
         default: ;
      endcase

      if (sift_done) begin
         if (!pop_phase_ff) begin
            if (bld_ff == '0) begin
               pop_phase_in = 1'b1;
            end else begin
               bld_in = bld_ff - 1'b1;
               idx_in = bld_ff - 1'b1;
            end
         end else if (k_ff == fill_ff) begin
            // set done: start a new one
            fill_in = '0;
            ovf_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd0_ff <= heap_mem[rd_addr0];
      rd1_ff <= heap_mem[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsr_pkg::ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         pop_phase_ff <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         pop_phase_ff <= pop_phase_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bld_ff      <= bld_in;
      idx_ff      <= idx_in;
      sift_n_ff   <= sift_n_in;
      hold_ff     <= hold_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.position = rsp_pos_ff;
   assign rsp_bus.rank     = rsp_rank_ff;
   assign rsp_bus.run_end  = rsp_end_ff;
   assign rsp_bus.overflow = rsp_ovf_ff;

endmodule
